// ----- hdl/irpg_pkg.sv -----
// Shared types and constants of the infrared remote pulse generator.
// Used by the channel interfaces and by the top level; depends on nothing.
package irpg_pkg;

	// Default largest frame length in bits.
	localparam int MAX_FRAME_BITS_DEF = 32;

	// Longest space sent in one word while the frame gap runs out.
	localparam int GAP_CHUNK = 32000;

	// Largest mark or space taken from a timing field.
	localparam int MARK_MAX = 32767;

	// Field widths of the configuration registers.
	localparam int TIMING_W = 30;
	localparam int TAIL_W   = 15;
	localparam int GAP_W    = 20;
	localparam int FIXED_W  = 32;
	localparam int COUNTS_W = 12;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_HEADER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS = 3'd7;

	// Input word kinds.
	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// Sequencer phases, one-hot.
	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_HSPACE = 6'b000010,
		PH_DATA   = 6'b000100,
		PH_TAIL   = 6'b001000,
		PH_GAP    = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	// Command word: start a frame or request the next duration.
	typedef struct packed {
		logic        kind;
		logic [31:0] code_value;
	} cmd_t;

	// Result word: one duration of the waveform.
	typedef struct packed {
		logic signed [15:0] duration;
		logic               frame_done;
	} rsp_t;

endpackage

// ----- hdl/irpg_if.sv -----
// Valid/ready channels of the infrared remote pulse generator.
// Depends on irpg_pkg for the payload types.
interface irpg_cmd_if;
	logic              valid;
	logic              ready;
	irpg_pkg::cmd_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface irpg_rsp_if;
	logic              valid;
	logic              ready;
	irpg_pkg::rsp_t    payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/ir_remote_pulse_generator.sv -----
// Top level of the infrared remote pulse generator: frame packing, phase
// sequencer and duration output. Depends on irpg_pkg and irpg_if.sv.
//
//  channel  | direction | word
//  ---------+-----------+---------------------------------------------
//  cmd      | in        | kind, code_value (start or request)
//  rsp      | out       | duration (signed), frame_done
//  cfg_*    | in        | register write: cfg_we, cfg_index, cfg_data
//
// One word per cycle while the result register is not stalled: a command
// word is taken into the input register and then handled by one pass of
// short logic into the result register.
// A start word gives no result. Reset clears the sequencer, the configuration registers and the valid flags.
// A stalled result register holds its word and stops the input stage only
// when a request would need it.
module ir_remote_pulse_generator #(
	parameter int MAX_FRAME_BITS = irpg_pkg::MAX_FRAME_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	irpg_cmd_if.sink                             cmd,
	irpg_rsp_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic [irpg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [irpg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int STEP_W = $clog2(2 * MAX_FRAME_BITS + 1);
	localparam int IDX_W  = STEP_W - 1;
	localparam int FB_EXT = 2 ** IDX_W;
	localparam int TOT_W  = $clog2(MAX_FRAME_BITS + 1);
	localparam int ELAP_RUN = $clog2((2 * MAX_FRAME_BITS + 3) * irpg_pkg::MARK_MAX + 1);
	localparam int ELAP_W = (ELAP_RUN > irpg_pkg::GAP_W) ? ELAP_RUN : irpg_pkg::GAP_W;

	// Configuration registers.
	logic [irpg_pkg::TIMING_W-1:0] header_q, zero_q, one_q, repeat_q;
	logic [irpg_pkg::TAIL_W-1:0]   tail_q;
	logic [irpg_pkg::GAP_W-1:0]    gap_q;
	logic [irpg_pkg::FIXED_W-1:0]  fixed_q;
	logic [irpg_pkg::COUNTS_W-1:0] counts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			zero_q   <= '0;
			one_q    <= '0;
			repeat_q <= '0;
			tail_q   <= '0;
			gap_q    <= '0;
			fixed_q  <= '0;
			counts_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				irpg_pkg::REG_HEADER: header_q <= cfg_data[irpg_pkg::TIMING_W-1:0];
				irpg_pkg::REG_ZERO:   zero_q   <= cfg_data[irpg_pkg::TIMING_W-1:0];
				irpg_pkg::REG_ONE:    one_q    <= cfg_data[irpg_pkg::TIMING_W-1:0];
				irpg_pkg::REG_REPEAT: repeat_q <= cfg_data[irpg_pkg::TIMING_W-1:0];
				irpg_pkg::REG_TAIL:   tail_q   <= cfg_data[irpg_pkg::TAIL_W-1:0];
				irpg_pkg::REG_GAP:    gap_q    <= cfg_data[irpg_pkg::GAP_W-1:0];
				irpg_pkg::REG_FIXED:  fixed_q  <= cfg_data[irpg_pkg::FIXED_W-1:0];
				irpg_pkg::REG_COUNTS: counts_q <= cfg_data[irpg_pkg::COUNTS_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input register moves on when its word needs no result
	// slot or the result slot is free this cycle.
	logic           valid_s1;
	irpg_pkg::cmd_t cmd_s1;
	logic           rsp_valid_q;
	irpg_pkg::rsp_t rsp_q;
	logic           slot_free;
	logic           advance;
	logic           is_req;

	assign is_req    = (cmd_s1.kind == irpg_pkg::KIND_REQUEST);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign advance   = valid_s1 && (!is_req || slot_free);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.payload;
		end
	end

	// Sequencer state.
	irpg_pkg::phase_t          phase_q;
	logic [STEP_W-1:0]         step_q;
	logic                      rep_q;
	logic [ELAP_W-1:0]         elapsed_q;
	logic [MAX_FRAME_BITS-1:0] bits_q;
	logic                      gap_started_q;

	// Frame packing: each bit position picks its source bit on its own.
	logic [5:0]                fix_cnt, code_cnt;
	logic [MAX_FRAME_BITS-1:0] packed_bits;
	logic [7:0]                pos, bsel;

	assign fix_cnt  = counts_q[5:0];
	assign code_cnt = counts_q[11:6];

	always_comb begin
		packed_bits = '0;
		pos  = '0;
		bsel = '0;
		for (int p = 0; p < MAX_FRAME_BITS; p++) begin
			pos = 8'(p);
			if (pos < {2'b00, fix_cnt}) begin
				bsel = {2'b00, fix_cnt} - 8'd1 - pos;
				packed_bits[p] = (bsel < 8'd32) ? fixed_q[bsel[4:0]] : 1'b0;
			end else if (pos < ({2'b00, fix_cnt} + {2'b00, code_cnt})) begin
				bsel = {2'b00, fix_cnt} + {2'b00, code_cnt} - 8'd1 - pos;
				packed_bits[p] = (bsel < 8'd32) ? cmd_s1.code_value[bsel[4:0]] : 1'b0;
			end
		end
	end

	// Clipped total bit count.
	logic [6:0]       tot_sum;
	logic [TOT_W-1:0] total;

	assign tot_sum = {1'b0, fix_cnt} + {1'b0, code_cnt};
	assign total   = (tot_sum > 7'(MAX_FRAME_BITS)) ? TOT_W'(MAX_FRAME_BITS)
		: TOT_W'(tot_sum);

	// One request: the finished-frame case first turns into a repeat header.
	irpg_pkg::phase_t  eff_phase, nx_phase;
	logic              eff_rep;
	logic [STEP_W-1:0] eff_step, nx_step, step_inc;
	logic [ELAP_W-1:0] eff_elapsed, nx_elapsed;
	logic [ELAP_W:0]   rest;
	logic [ELAP_W-1:0] gap_left;
	logic              nx_gap_started;
	logic [FB_EXT-1:0] bits_ext;
	logic              bit_one;
	logic [irpg_pkg::TIMING_W-1:0] bit_timing;
	logic [14:0]       len;
	logic              is_space;
	logic signed [15:0] dur;
	logic              done;

	assign bits_ext = FB_EXT'(bits_q);

	always_comb begin
		eff_phase   = phase_q;
		eff_rep     = rep_q;
		eff_step    = step_q;
		eff_elapsed = elapsed_q;
		if (phase_q == irpg_pkg::PH_DONE) begin
			eff_phase   = irpg_pkg::PH_HEADER;
			eff_rep     = 1'b1;
			eff_step    = '0;
			eff_elapsed = '0;
		end

		nx_phase       = eff_phase;
		nx_step        = eff_step;
		nx_elapsed     = eff_elapsed;
		nx_gap_started = gap_started_q;
		step_inc       = eff_step + STEP_W'(1);
		bit_one        = bits_ext[eff_step[STEP_W-1:1]];
		bit_timing     = bit_one ? one_q : zero_q;
		rest           = {1'b0, ELAP_W'(gap_q)} - {1'b0, eff_elapsed};
		gap_left       = eff_elapsed;
		len            = '0;
		is_space       = 1'b0;
		dur            = '0;
		done           = 1'b0;

		case (eff_phase)
			irpg_pkg::PH_HEADER: begin
				if (eff_rep) begin
					if (eff_step == '0) begin
						nx_step = STEP_W'(1);
						len     = repeat_q[14:0];
					end else begin
						nx_phase = irpg_pkg::PH_TAIL;
						len      = repeat_q[29:15];
						is_space = 1'b1;
					end
				end else begin
					nx_phase = irpg_pkg::PH_HSPACE;
					len      = header_q[14:0];
				end
			end
			irpg_pkg::PH_HSPACE: begin
				nx_phase = irpg_pkg::PH_DATA;
				len      = header_q[29:15];
				is_space = 1'b1;
			end
			irpg_pkg::PH_DATA: begin
				is_space = eff_step[0];
				len      = eff_step[0] ? bit_timing[29:15] : bit_timing[14:0];
				nx_step  = step_inc;
				if ({1'b0, step_inc} >= (STEP_W + 1)'({total, 1'b0})) begin
					nx_phase = irpg_pkg::PH_TAIL;
				end
			end
			irpg_pkg::PH_TAIL: begin
				nx_phase       = irpg_pkg::PH_GAP;
				nx_step        = '0;
				nx_gap_started = 1'b0;
				len            = tail_q;
			end
			default: begin
				// Gap: the frame remainder goes out in bounded spaces.
				if (!gap_started_q) begin
					gap_left       = rest[ELAP_W] ? '0 : rest[ELAP_W-1:0];
					nx_gap_started = 1'b1;
				end
			end
		endcase

		if (eff_phase == irpg_pkg::PH_GAP) begin
			if (gap_left > ELAP_W'(irpg_pkg::GAP_CHUNK)) begin
				nx_elapsed = gap_left - ELAP_W'(irpg_pkg::GAP_CHUNK);
				dur        = -16'sd32000;
			end else begin
				nx_elapsed = gap_left;
				nx_phase   = irpg_pkg::PH_DONE;
				dur        = -$signed(16'(gap_left));
				done       = 1'b1;
			end
		end else begin
			nx_elapsed = eff_elapsed + ELAP_W'(len);
			dur        = is_space ? -$signed({1'b0, len}) : $signed({1'b0, len});
		end
	end

	// State update: a start word resets the sequencer and loads the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= irpg_pkg::PH_HEADER;
			step_q        <= '0;
			rep_q         <= 1'b0;
			elapsed_q     <= '0;
			bits_q        <= '0;
			gap_started_q <= 1'b0;
		end else if (advance) begin
			if (!is_req) begin
				phase_q       <= irpg_pkg::PH_HEADER;
				step_q        <= '0;
				rep_q         <= 1'b0;
				elapsed_q     <= '0;
				bits_q        <= packed_bits;
				gap_started_q <= 1'b0;
			end else begin
				phase_q       <= nx_phase;
				step_q        <= nx_step;
				rep_q         <= eff_rep;
				elapsed_q     <= nx_elapsed;
				gap_started_q <= nx_gap_started;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (slot_free) begin
			rsp_valid_q <= advance && is_req;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_req) begin
			rsp_q.duration   <= dur;
			rsp_q.frame_done <= done;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule
